>>> sv/emoji_stream_bit_decoder_macros.svh
// ----------------------------------------------------------------------------
// Emoji stream bit decoder assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef EMOJI_STREAM_BIT_DECODER_MACROS_SVH
`define EMOJI_STREAM_BIT_DECODER_MACROS_SVH

`ifndef SYNTHESIS
`define ESBD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("esbd: implication check failed");
`define ESBD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("esbd: next-cycle check failed");
`else
`define ESBD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ESBD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

>>> sv/esbd_pkg.sv
// ----------------------------------------------------------------------------
// esbd_pkg
// Shared types and constants of the emoji stream bit decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package esbd_pkg;

  typedef enum logic [2:0] {
    REG_XOR_KEY     = 3'd0,
    REG_ZERO_CODE_A = 3'd1,
    REG_ZERO_CODE_B = 3'd2,
    REG_ZERO_CODE_C = 3'd3,
    REG_ONE_CODE_A  = 3'd4,
    REG_ONE_CODE_B  = 3'd5,
    REG_ONE_CODE_C  = 3'd6
  } reg_idx_t;

  localparam logic [7:0]  XOR_KEY_RST     = 8'h5A;
  localparam logic [31:0] ZERO_CODE_A_RST = 32'hF09F9982;
  localparam logic [31:0] ZERO_CODE_B_RST = 32'hF09F9880;
  localparam logic [31:0] ZERO_CODE_C_RST = 32'hF09F9883;
  localparam logic [31:0] ONE_CODE_A_RST  = 32'hF09F988C;
  localparam logic [31:0] ONE_CODE_B_RST  = 32'hF09F9889;
  localparam logic [31:0] ONE_CODE_C_RST  = 32'hF09F9881;

  typedef struct packed {
    logic [31:0] char_bytes;
    logic [2:0]  char_length;
    logic [2:0]  bytes_held;
    logic [6:0]  bit_shift;
    logic [2:0]  bits_held;
  } state_t;

  typedef struct packed {
    logic [7:0]       xor_key;
    logic [2:0][31:0] zero_codes;
    logic [2:0][31:0] one_codes;
  } codes_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data_byte;
    logic       status;
  } result_t;

endpackage

`default_nettype wire

>>> sv/esbd_step.sv
// ----------------------------------------------------------------------------
// esbd_step
// Per-byte character assembly, code match and bit packing.
// ----------------------------------------------------------------------------
`default_nettype none

module esbd_step import esbd_pkg::*; (
  input  state_t     st,
  input  codes_t     codes,
  input  logic [7:0] data_in,
  input  logic       eos,
  output state_t     st_nxt,
  output result_t    res
);

  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_VAL  = 8'hF0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_VAL  = 8'hE0;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_VAL  = 8'hC0;

  function automatic logic [2:0] lead_length(input logic [7:0] b);
    logic [2:0] len;
    if ((b & LEAD4_MASK) == LEAD4_VAL) len = 3'd4;
    else if ((b & LEAD3_MASK) == LEAD3_VAL) len = 3'd3;
    else if ((b & LEAD2_MASK) == LEAD2_VAL) len = 3'd2;
    else len = 3'd1;
    return len;
  endfunction

  logic [31:0] cb;
  logic [2:0]  len;
  logic [2:0]  bh;
  logic        done;
  logic        is_four;
  logic        zero_hit;
  logic        one_hit;
  logic        bit_val;

  always_comb begin
    if (st.char_length == 3'd0) begin
      len = lead_length(data_in);
      cb  = {24'd0, data_in};
      bh  = 3'd1;
    end else begin
      len = st.char_length;
      cb  = {st.char_bytes[23:0], data_in};
      bh  = st.bytes_held + 3'd1;
    end
    done     = (bh >= len);
    is_four  = (len == 3'd4);
    zero_hit = is_four && ((cb == codes.zero_codes[0]) || (cb == codes.zero_codes[1]) ||
                           (cb == codes.zero_codes[2]));
    one_hit  = is_four && !zero_hit &&
               ((cb == codes.one_codes[0]) || (cb == codes.one_codes[1]) ||
                (cb == codes.one_codes[2]));
    bit_val  = one_hit;

    st_nxt             = st;
    st_nxt.char_bytes  = cb;
    st_nxt.char_length = len;
    st_nxt.bytes_held  = bh;
    res                = '0;

    if (done) begin
      if (!zero_hit && !one_hit) begin
        res.valid  = 1'b1;
        res.status = 1'b1;
      end else if (st.bits_held == 3'd7) begin
        res.valid        = 1'b1;
        res.data_byte    = {st.bit_shift, bit_val} ^ codes.xor_key;
        st_nxt.bit_shift = '0;
        st_nxt.bits_held = '0;
      end else begin
        st_nxt.bit_shift = {st.bit_shift[5:0], bit_val};
        st_nxt.bits_held = st.bits_held + 3'd1;
      end
      st_nxt.char_bytes  = '0;
      st_nxt.char_length = '0;
      st_nxt.bytes_held  = '0;
    end

    // drop partial character and bits
    if (eos) begin
      st_nxt = '0;
    end
  end

endmodule

`default_nettype wire

>>> sv/emoji_stream_bit_decoder.sv
// ----------------------------------------------------------------------------
// emoji_stream_bit_decoder: UTF-8 emoji stream to keyed byte decoder
// Path: an accepted request passes the input register, then the result register.
// Throughput: one input byte per cycle while out_stall does not hold a full result register.
// Reset: synchronous rst_n clears control and decode state and restores register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

`include "emoji_stream_bit_decoder_macros.svh"

module emoji_stream_bit_decoder import esbd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_end_of_stream,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_data_byte,
  output logic        out_status,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  codes_t     codes_r;
  reg_idx_t   reg_idx;
  logic       cfg_wr;

  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       in_eos_r;
  logic       in_acc;
  logic       adv;

  state_t     st_r;
  state_t     st_nxt;
  result_t    res;

  logic       out_valid_r;
  logic [7:0] out_data_byte_r;
  logic       out_status_r;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      codes_r.xor_key       <= XOR_KEY_RST;
      codes_r.zero_codes[0] <= ZERO_CODE_A_RST;
      codes_r.zero_codes[1] <= ZERO_CODE_B_RST;
      codes_r.zero_codes[2] <= ZERO_CODE_C_RST;
      codes_r.one_codes[0]  <= ONE_CODE_A_RST;
      codes_r.one_codes[1]  <= ONE_CODE_B_RST;
      codes_r.one_codes[2]  <= ONE_CODE_C_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_XOR_KEY:     codes_r.xor_key       <= pwdata[7:0];
        REG_ZERO_CODE_A: codes_r.zero_codes[0] <= pwdata;
        REG_ZERO_CODE_B: codes_r.zero_codes[1] <= pwdata;
        REG_ZERO_CODE_C: codes_r.zero_codes[2] <= pwdata;
        REG_ONE_CODE_A:  codes_r.one_codes[0]  <= pwdata;
        REG_ONE_CODE_B:  codes_r.one_codes[1]  <= pwdata;
        REG_ONE_CODE_C:  codes_r.one_codes[2]  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_XOR_KEY:     prdata = {24'd0, codes_r.xor_key};
      REG_ZERO_CODE_A: prdata = codes_r.zero_codes[0];
      REG_ZERO_CODE_B: prdata = codes_r.zero_codes[1];
      REG_ZERO_CODE_C: prdata = codes_r.zero_codes[2];
      REG_ONE_CODE_A:  prdata = codes_r.one_codes[0];
      REG_ONE_CODE_B:  prdata = codes_r.one_codes[1];
      REG_ONE_CODE_C:  prdata = codes_r.one_codes[2];
      default:         prdata = '0;
    endcase
  end

  assign adv      = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !adv;
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_acc) begin
      in_valid_r <= 1'b1;
    end else if (adv) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_byte_r <= in_byte;
      in_eos_r  <= in_end_of_stream;
    end
  end

  esbd_step u_step (
    .st      (st_r),
    .codes   (codes_r),
    .data_in (in_byte_r),
    .eos     (in_eos_r),
    .st_nxt  (st_nxt),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (adv) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && res.valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res.valid) begin
      out_data_byte_r <= res.data_byte;
      out_status_r    <= res.status;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_data_byte = out_data_byte_r;
  assign out_status    = out_status_r;

  `ESBD_ASSERT_IMPL(a_unknown_zero, clk, rst_n, out_valid_r && out_status_r, out_data_byte_r == 8'd0)
  `ESBD_ASSERT_IMPL(a_open_partial, clk, rst_n, st_r.char_length != 3'd0, st_r.bytes_held < st_r.char_length)
  `ESBD_ASSERT_IMPL(a_closed_empty, clk, rst_n, st_r.char_length == 3'd0, st_r.bytes_held == 3'd0 && st_r.char_bytes == 32'd0)
  `ESBD_ASSERT_NEXT(a_eos_clears, clk, rst_n, adv && in_eos_r, st_r == '0)

endmodule

`default_nettype wire
